// ----- hdl/lpr_pkg.sv -----
// ---------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the LRU page replacement block
// Frame count, widths, configuration register indexes, saturating add.
// ---------------------------------------------------------------------------
package lpr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int ID_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int SLOT_W    = 3;
    localparam int COST_W    = 13;
    localparam int TIME_W    = 10;
    localparam int FIU_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [COST_W-1:0]    t_cost;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [FIU_W-1:0]     t_fiu;
    typedef logic [31:0]          t_count;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB_TIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENABLE    = 3'd4;

    // one recency position: which frame, and the page that frame holds
    typedef struct packed {
        t_id   id;
        t_page page;
    } t_entry;

    // per-cell control from the top level
    typedef struct packed {
        logic valid;   // position is below the fill count
        logic shift;   // take the entry of the next position
        logic load;    // take the new most-recent entry
    } t_cell_ctl;

    function automatic t_count sat_add(input t_count a, input t_cost b);
        logic [32:0] s;
        s = {1'b0, a} + {20'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- hdl/lpr_ref_if.sv -----
// ---------------------------------------------------------------------------
// lpr_ref_if: page reference channel
// valid/ready handshake carrying one page reference per beat.
// ---------------------------------------------------------------------------
interface lpr_ref_if;
    logic          valid;
    logic          ready;
    lpr_pkg::t_page page_number;
    logic          restart;

    modport source (output valid, output page_number, output restart, input ready);
    modport sink   (input valid, input page_number, input restart, output ready);
    modport mon    (input valid, input page_number, input restart, input ready);
endinterface

// ----- hdl/lpr_res_if.sv -----
// ---------------------------------------------------------------------------
// lpr_res_if: result channel
// valid/ready handshake carrying one reference result per beat.
// ---------------------------------------------------------------------------
interface lpr_res_if;
    logic            valid;
    logic            ready;
    logic            hit;
    lpr_pkg::t_slot  slot;
    logic            evicted_valid;
    lpr_pkg::t_page  evicted_page;
    lpr_pkg::t_count fault_count;
    lpr_pkg::t_cost  access_cost;
    lpr_pkg::t_count total_cost;
    lpr_pkg::t_count access_index;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_page, output fault_count, output access_cost,
                    output total_cost, output access_index, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input fault_count, input access_cost,
                    input total_cost, input access_index, output ready);
    modport mon    (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input fault_count, input access_cost,
                    input total_cost, input access_index, input ready);
endinterface

// ----- hdl/lpr_cell.sv -----
// ---------------------------------------------------------------------------
// lpr_cell: one recency position of the LRU chain
// Holds a frame id and its page, compares against the reference, and
// passes a "match seen" flag toward the most-recent end.
// ---------------------------------------------------------------------------
module lpr_cell (
    input  logic               i_clk,
    input  lpr_pkg::t_cell_ctl i_ctl,
    input  lpr_pkg::t_entry    i_next,     // entry of the next position
    input  lpr_pkg::t_entry    i_new,      // new most-recent entry
    input  lpr_pkg::t_page     i_page,     // referenced page
    input  logic               i_seen,     // match at an older position
    output logic               o_seen,
    output logic               o_hit,
    output lpr_pkg::t_entry    o_entry
);

    lpr_pkg::t_entry r_entry;

    assign o_hit   = i_ctl.valid && (r_entry.page == i_page);
    assign o_seen  = i_seen || o_hit;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

endmodule

// ----- hdl/lru_page_replacement.sv -----
// ---------------------------------------------------------------------------
// lru_page_replacement: LRU page replacement with access cost accounting
// A chain of FRAMES cells holds the recency order, least recent at cell 0,
// each cell carrying its frame id and page. One reference per cycle while o_res does not stall.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake      beat contents
//  --------  ---  -------------  -------------------------------------------
//  i_ref     in   valid/ready    page_number, restart
//  o_res     out  valid/ready    hit, slot, evicted_valid, evicted_page,
//                                fault_count, access_cost, total_cost,
//                                access_index
//  i_cfg_*   in   write enable   register index, 10-bit data
//
//  A reference is resolved in the cycle it is accepted: all cells compare
//  in parallel, the chain shifts, and the result is registered in the output
//  register. One reference per cycle sustained while o_res does not stall.
//  i_ref.ready is low only while a result sits in the output register and
//  o_res.ready is low. Synchronous active-low reset clears the fill count
//  and counters and sets the config registers to defaults; cell contents
//  are not reset and are never read above the fill count.
//
module lru_page_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lpr_ref_if.sink                           i_ref,
    lpr_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpr_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    // config registers
    lpr_pkg::t_fiu  r_fiu;
    lpr_pkg::t_time r_mem_time;
    lpr_pkg::t_time r_fault_time;
    lpr_pkg::t_time r_tlb_time;
    logic           r_tlb_en;

    // run state
    lpr_pkg::t_cnt   r_filled;
    lpr_pkg::t_count r_faults;
    lpr_pkg::t_count r_cost_sum;
    lpr_pkg::t_count r_refs;

    // output register
    logic            r_out_valid;
    logic            r_hit;
    lpr_pkg::t_slot  r_slot;
    logic            r_ev_valid;
    lpr_pkg::t_page  r_ev_page;
    lpr_pkg::t_count r_fault_count;
    lpr_pkg::t_cost  r_cost;
    lpr_pkg::t_count r_total;
    lpr_pkg::t_count r_index;

    logic               accept;
    lpr_pkg::t_cnt      filled_eff;
    lpr_pkg::t_count    faults_eff;
    lpr_pkg::t_count    cost_eff;
    lpr_pkg::t_count    refs_eff;
    logic               any_hit;
    logic               do_fill;
    logic               do_evict;
    logic               room;
    lpr_pkg::t_id       hit_id;
    lpr_pkg::t_entry    new_entry;
    lpr_pkg::t_id       slot_id;
    lpr_pkg::t_cost     cost;
    lpr_pkg::t_cost     mem3;

    lpr_pkg::t_cell_ctl ctl   [lpr_pkg::FRAMES];
    lpr_pkg::t_entry    entry [lpr_pkg::FRAMES];
    logic               seen  [lpr_pkg::FRAMES+1];
    logic               hit_v [lpr_pkg::FRAMES];

    lpr_pkg::t_cnt      n_filled;
    lpr_pkg::t_count    n_faults;

    assign i_ref.ready = !r_out_valid || o_res.ready;
    assign accept      = i_ref.valid && i_ref.ready;

    // restart zeroes the run state in front of this reference
    assign filled_eff = i_ref.restart ? '0 : r_filled;
    assign faults_eff = i_ref.restart ? '0 : r_faults;
    assign cost_eff   = i_ref.restart ? '0 : r_cost_sum;
    assign refs_eff   = i_ref.restart ? '0 : r_refs;

    // ---- cell chain ------------------------------------------------------
    assign seen[0] = 1'b0;

    for (genvar g = 0; g < lpr_pkg::FRAMES; g++) begin : g_cell
        lpr_pkg::t_entry next_e;
        if (g == lpr_pkg::FRAMES - 1) begin : g_last
            assign next_e = entry[g];
        end else begin : g_mid
            assign next_e = entry[g+1];
        end

        lpr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl[g]),
            .i_next  (next_e),
            .i_new   (new_entry),
            .i_page  (i_ref.page_number),
            .i_seen  (seen[g]),
            .o_seen  (seen[g+1]),
            .o_hit   (hit_v[g]),
            .o_entry (entry[g])
        );
    end

    // hit lookup: the matching cell supplies its frame id
    always_comb begin
        any_hit = 1'b0;
        hit_id  = '0;
        for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
            if (hit_v[i]) begin
                any_hit = 1'b1;
                hit_id  = hit_id | entry[i].id;
            end
        end
    end

    // frames_in_use of 0 acts as 1, above FRAMES acts as FRAMES
    always_comb begin
        if (r_fiu == '0) begin
            room = (filled_eff == '0);
        end else begin
            room = (32'(filled_eff) < 32'(r_fiu))
                   && (32'(filled_eff) < lpr_pkg::FRAMES);
        end
    end

    assign do_fill  = !any_hit && room;
    assign do_evict = !any_hit && !room;

    // frame id of the new most-recent entry
    always_comb begin
        if (any_hit) begin
            slot_id = hit_id;
        end else if (do_fill) begin
            slot_id = lpr_pkg::ID_W'(filled_eff);
        end else begin
            slot_id = entry[0].id;          // least recent frame is replaced
        end
    end

    assign new_entry.id   = slot_id;
    assign new_entry.page = i_ref.page_number;

    // per-position shift/load
    always_comb begin
        for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
            ctl[i].valid = 32'(filled_eff) > i;
            ctl[i].shift = accept && (32'(filled_eff) > i + 1)
                           && (any_hit ? seen[i+1] : do_evict);
            ctl[i].load  = accept &&
                           (do_fill ? (32'(filled_eff) == i)
                                    : (32'(filled_eff) == i + 1));
        end
    end

    // ---- cost ------------------------------------------------------------
    assign mem3 = lpr_pkg::COST_W'(r_mem_time) + lpr_pkg::COST_W'({r_mem_time, 1'b0});

    always_comb begin
        if (any_hit) begin
            cost = r_tlb_en ? (lpr_pkg::COST_W'(r_tlb_time) + lpr_pkg::COST_W'(r_mem_time))
                            : lpr_pkg::COST_W'({r_mem_time, 1'b0});
        end else begin
            cost = mem3 + lpr_pkg::COST_W'(r_fault_time)
                 + (r_tlb_en ? lpr_pkg::COST_W'(r_tlb_time) : '0);
        end
    end

    assign n_filled = do_fill ? filled_eff + lpr_pkg::CNT_W'(1) : filled_eff;
    assign n_faults = any_hit ? faults_eff : lpr_pkg::sat_add(faults_eff, 13'd1);

    // ---- registers -------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu        <= 4'd8;
            r_mem_time   <= 10'd100;
            r_fault_time <= 10'd105;
            r_tlb_time   <= 10'd5;
            r_tlb_en     <= 1'b0;
            r_filled     <= '0;
            r_faults     <= '0;
            r_cost_sum   <= '0;
            r_refs       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lpr_pkg::CFG_FRAMES_IN_USE: r_fiu        <= i_cfg_data[lpr_pkg::FIU_W-1:0];
                    lpr_pkg::CFG_MEMORY_TIME:   r_mem_time   <= i_cfg_data;
                    lpr_pkg::CFG_FAULT_TIME:    r_fault_time <= i_cfg_data;
                    lpr_pkg::CFG_TLB_TIME:      r_tlb_time   <= i_cfg_data;
                    lpr_pkg::CFG_TLB_ENABLE:    r_tlb_en     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_filled    <= n_filled;
                r_faults    <= n_faults;
                r_cost_sum  <= lpr_pkg::sat_add(cost_eff, cost);
                r_refs      <= lpr_pkg::sat_add(refs_eff, 13'd1);
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit         <= any_hit;
            r_slot        <= lpr_pkg::t_slot'(slot_id);
            r_ev_valid    <= do_evict;
            r_ev_page     <= do_evict ? entry[0].page : '0;
            r_fault_count <= n_faults;
            r_cost        <= cost;
            r_total       <= lpr_pkg::sat_add(cost_eff, cost);
            r_index       <= refs_eff;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.hit           = r_hit;
    assign o_res.slot          = r_slot;
    assign o_res.evicted_valid = r_ev_valid;
    assign o_res.evicted_page  = r_ev_page;
    assign o_res.fault_count   = r_fault_count;
    assign o_res.access_cost   = r_cost;
    assign o_res.total_cost    = r_total;
    assign o_res.access_index  = r_index;

endmodule

// ----- hdl/lpr_checker.sv -----
// ---------------------------------------------------------------------------
// lpr_checker: port-level checks for lru_page_replacement
// Result hold under stall, accept-to-result timing, hit/evict consistency.
// ---------------------------------------------------------------------------
module lpr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_ref_valid,
    input logic            i_ref_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input logic            i_res_hit,
    input lpr_pkg::t_slot  i_res_slot,
    input logic            i_res_evicted_valid,
    input lpr_pkg::t_page  i_res_evicted_page,
    input lpr_pkg::t_count i_res_total_cost,
    input lpr_pkg::t_count i_res_access_index
);

    // a stalled result beat stays up
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_hit) && $stable(i_res_slot) && $stable(i_res_total_cost)
            && $stable(i_res_access_index) && $stable(i_res_evicted_page))
        else $error("result payload changed while stalled");

    // every accepted reference shows a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ref_valid && i_ref_ready |=> i_res_valid)
        else $error("accepted reference produced no result");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_hit |-> !i_res_evicted_valid && (i_res_evicted_page == '0))
        else $error("eviction reported on a hit");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_ref_valid         (i_ref.valid),
    .i_ref_ready         (i_ref.ready),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_res_hit           (o_res.hit),
    .i_res_slot          (o_res.slot),
    .i_res_evicted_valid (o_res.evicted_valid),
    .i_res_evicted_page  (o_res.evicted_page),
    .i_res_total_cost    (o_res.total_cost),
    .i_res_access_index  (o_res.access_index)
);
